@@ design/hse_pkg.sv @@
// ----------------------------------------------------------------------------
// hse_pkg
// shared types for the heap sort engine: item payloads and sift-step select
// ----------------------------------------------------------------------------
package hse_pkg;

    localparam int KEY_W = 32;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef struct packed {
        logic signed [KEY_W-1:0] value;
        logic                    last;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_value;
        logic                    final_res;
        logic                    overflow;
    } t_out_item;

    // outcome of one sift-down compare step
    typedef struct packed {
        logic move;        // a child is larger than the sinking value
        logic take_right;  // the right child is the one to promote
    } t_sift_sel;

endpackage

@@ design/hse_mem.sv @@
// ----------------------------------------------------------------------------
// hse_mem
// element store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module hse_mem #(
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  hse_pkg::t_key      i_wdata,
    input  logic [AW-1:0]      i_raddr_a,
    input  logic [AW-1:0]      i_raddr_b,
    output hse_pkg::t_key      o_rdata_a,
    output hse_pkg::t_key      o_rdata_b
);
    import hse_pkg::*;

    t_key r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ design/hse_cmp.sv @@
// ----------------------------------------------------------------------------
// hse_cmp
// sift-down compare unit: picks the larger child if it beats the sinking value
// ----------------------------------------------------------------------------
module hse_cmp (
    input  hse_pkg::t_key      i_cur,
    input  hse_pkg::t_key      i_left,
    input  hse_pkg::t_key      i_right,
    input  logic               i_left_ok,
    input  logic               i_right_ok,
    output hse_pkg::t_sift_sel o_sel
);
    import hse_pkg::*;

    logic left_wins;
    logic right_wins;
    t_key big_val;

    // ties keep the parent, and the left child on equal children
    always_comb begin
        left_wins        = i_left_ok && (i_left > i_cur);
        big_val          = left_wins ? i_left : i_cur;
        right_wins       = i_right_ok && (i_right > big_val);
        o_sel.move       = left_wins || right_wins;
        o_sel.take_right = right_wins;
    end

endmodule

@@ design/heap_sort_engine_unit.sv @@
// ----------------------------------------------------------------------------
// heap_sort_engine_unit
// collects signed values, heapsorts them in place and returns them ascending
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_valid / o_ready, payload i_data) takes one value per
//   item, one item per cycle while loading; the item with last set closes
//   the set. values past DEPTH are dropped and overflow is flagged on every
//   result of that run.
//   output channel (o_valid / i_ready, payload o_data) returns one item per
//   stored value in ascending order, final_res set on the largest.
// sort flow:
//   the sort runs one shared compare unit against a two-read, one-write
//   store: each sift level reads both children, then compares and moves
//   the hole; each build node first reads and latches the node to sink;
//   each extraction reads root and heap end, then moves the old root to
//   the heap end. results are read out once the output register is free.
//   o_ready is low from the last item until the final result is registered.
// reset: synchronous active-low; clears count, overflow flag and output
//   valid. the store itself is not cleared, only written entries are read.
// stall: a stalled result holds in the output register; the sequencer waits.
//   after the final result is registered the block loads again at once.
// ----------------------------------------------------------------------------
module heap_sort_engine_unit #(
    parameter int DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hse_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output hse_pkg::t_out_item  o_data
);
    import hse_pkg::*;

    localparam int AW = $clog2(DEPTH);      // store address width
    localparam int NW = $clog2(DEPTH + 1);  // element count width
    localparam int CW = AW + 2;             // child index width

    typedef enum logic [3:0] {
        S_LOAD,      // take items into the store
        S_BLD_RD,    // build: read the node to sink
        S_BLD_CUR,   // build: latch the sinking value
        S_SIFT_RD,   // read both children of the hole
        S_SIFT_CMP,  // compare, then move a child up or drop the value in
        S_EX_RD,     // extract: read root and heap end
        S_EX_WR,     // extract: root to heap end, end value sinks from root
        S_OUT_RD,    // read next sorted entry once the output is free
        S_OUT_SHOW   // load the output register
    } t_state;

    t_state        r_state, n_state;
    logic [NW-1:0] r_cnt, n_cnt;       // stored elements, also heap length
    logic          r_drop, n_drop;     // something was dropped this set
    logic [AW-1:0] r_i, n_i;           // build node / heap end / output index
    logic          r_build, n_build;   // sift belongs to the build phase
    logic [AW-1:0] r_node, n_node;     // current hole position
    logic [NW-1:0] r_size, n_size;     // live heap size during a sift
    t_key          r_cur, n_cur;       // value sinking through the heap
    logic          r_ovalid, n_ovalid;
    t_out_item     r_odata, n_odata;

    // store ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_key          mem_wdata;
    logic [AW-1:0] mem_raddr_a;
    logic [AW-1:0] mem_raddr_b;
    t_key          mem_rdata_a;
    t_key          mem_rdata_b;

    // child indexes of the hole
    logic [CW-1:0] lc;
    logic [CW-1:0] rc;
    logic          lc_ok;
    logic          rc_ok;
    t_sift_sel     sel;

    logic          in_acc;
    logic          store_ok;
    logic [NW-1:0] cnt_after;

    assign in_acc    = i_valid && (r_state == S_LOAD);
    assign store_ok  = (r_cnt < NW'(DEPTH));
    assign cnt_after = store_ok ? r_cnt + NW'(1) : r_cnt;

    assign lc    = {1'b0, r_node, 1'b1};
    assign rc    = lc + CW'(1);
    assign lc_ok = (lc < CW'(r_size));
    assign rc_ok = (rc < CW'(r_size));

    hse_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_raddr_a(mem_raddr_a),
        .i_raddr_b(mem_raddr_b),
        .o_rdata_a(mem_rdata_a),
        .o_rdata_b(mem_rdata_b)
    );

    // shared compare unit, children come from the registered read ports
    hse_cmp u_cmp (
        .i_cur     (r_cur),
        .i_left    (mem_rdata_a),
        .i_right   (mem_rdata_b),
        .i_left_ok (lc_ok),
        .i_right_ok(rc_ok),
        .o_sel     (sel)
    );

    // store port steering
    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = r_cnt[AW-1:0];
        mem_wdata   = i_data.value;
        mem_raddr_a = r_i;
        mem_raddr_b = r_i;
        case (r_state)
            S_LOAD: begin
                mem_we = in_acc && store_ok;
            end
            S_SIFT_RD: begin
                mem_raddr_a = lc_ok ? lc[AW-1:0] : '0;
                mem_raddr_b = rc_ok ? rc[AW-1:0] : '0;
            end
            S_SIFT_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = r_node;
                if (sel.move) begin
                    mem_wdata = sel.take_right ? mem_rdata_b : mem_rdata_a;
                end else begin
                    mem_wdata = r_cur;
                end
            end
            S_EX_RD: begin
                mem_raddr_a = '0;
            end
            S_EX_WR: begin
                // old root goes to the end of the shrinking heap
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = mem_rdata_a;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_drop   = r_drop;
        n_i      = r_i;
        n_build  = r_build;
        n_node   = r_node;
        n_size   = r_size;
        n_cur    = r_cur;
        n_ovalid = r_ovalid && !i_ready;
        n_odata  = r_odata;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    n_cnt = cnt_after;
                    if (!store_ok) begin
                        n_drop = 1'b1;
                    end
                    if (i_data.last) begin
                        if (cnt_after < NW'(2)) begin
                            n_i     = '0;
                            n_state = S_OUT_RD;
                        end else begin
                            // build starts at the last parent
                            n_i     = AW'((cnt_after >> 1) - NW'(1));
                            n_build = 1'b1;
                            n_state = S_BLD_RD;
                        end
                    end
                end
            end
            S_BLD_RD: begin
                n_state = S_BLD_CUR;
            end
            S_BLD_CUR: begin
                n_cur   = mem_rdata_a;
                n_node  = r_i;
                n_size  = r_cnt;
                n_state = S_SIFT_RD;
            end
            S_SIFT_RD: begin
                n_state = S_SIFT_CMP;
            end
            S_SIFT_CMP: begin
                if (sel.move) begin
                    n_node  = sel.take_right ? rc[AW-1:0] : lc[AW-1:0];
                    n_state = S_SIFT_RD;
                end else if (r_build) begin
                    if (r_i == '0) begin
                        n_i     = AW'(r_cnt - NW'(1));
                        n_build = 1'b0;
                        n_state = S_EX_RD;
                    end else begin
                        n_i     = r_i - AW'(1);
                        n_state = S_BLD_RD;
                    end
                end else if (r_i == AW'(1)) begin
                    n_i     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_i     = r_i - AW'(1);
                    n_state = S_EX_RD;
                end
            end
            S_EX_RD: begin
                n_state = S_EX_WR;
            end
            S_EX_WR: begin
                n_cur   = mem_rdata_b;
                n_node  = '0;
                n_size  = NW'(r_i);
                n_state = S_SIFT_RD;
            end
            S_OUT_RD: begin
                if (!r_ovalid || i_ready) begin
                    n_state = S_OUT_SHOW;
                end
            end
            S_OUT_SHOW: begin
                n_ovalid             = 1'b1;
                n_odata.sorted_value = mem_rdata_a;
                n_odata.final_res    = (NW'(r_i) + NW'(1) == r_cnt);
                n_odata.overflow     = r_drop;
                if (NW'(r_i) + NW'(1) == r_cnt) begin
                    n_cnt   = '0;
                    n_drop  = 1'b0;
                    n_state = S_LOAD;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_state = S_OUT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
            r_build  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_drop   <= n_drop;
            r_ovalid <= n_ovalid;
            r_build  <= n_build;
        end
        r_i     <= n_i;
        r_node  <= n_node;
        r_size  <= n_size;
        r_cur   <= n_cur;
        r_odata <= n_odata;
    end

    assign o_ready = (r_state == S_LOAD);
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heap sort engine testbench
// loads sets of signed values into heap_sort_engine_unit and checks that each
// set comes back in ascending order, with final_res on the largest value and
// overflow on every result once more than DEPTH values were offered. a
// directed table of short sets runs first, then random sets of mixed size,
// under three idle patterns on the input and output channels
// ----------------------------------------------------------------------------
module testbench;
    import hse_pkg::*;

    localparam int  DEPTH       = 64;
    localparam int  CLK_PERIOD  = 4;
    localparam int  RESET_LEN   = 5;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_WAIT  = 64;
    localparam int  MAX_REPORTS = 10;

    localparam t_key KEY_MAX = 32'sh7FFF_FFFF;
    localparam t_key KEY_MIN = 32'sh8000_0000;

    // one row of the directed part; want is only used where typed is set
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    // current set as it stands inside the block, kept in ascending order
    t_key      set_ascending[$];
    bit        set_dropped;
    // results still owed by the block, oldest first
    t_out_item sorted_expect[$];

    int        send_idle_pct;
    int        recv_idle_pct;
    int        mismatch_count;
    int        cycle_count;

    t_stim_row stim_rows[$];

    heap_sort_engine_unit #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // run limit, counted from the very first edge
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, sorted_expect.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: decide ready on each falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // result check: an item leaves at a rising edge with o_valid and i_ready
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (sorted_expect.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: value %0d final %0b overflow %0b",
                             o_data.sorted_value, o_data.final_res, o_data.overflow);
            end else begin
                want = sorted_expect.pop_front();
                if (o_data.sorted_value !== want.sorted_value
                        || o_data.final_res !== want.final_res
                        || o_data.overflow !== want.overflow) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"mismatch: expected value %0d final %0b overflow %0b,",
                                  " got value %0d final %0b overflow %0b"},
                                 want.sorted_value, want.final_res, want.overflow,
                                 o_data.sorted_value, o_data.final_res, o_data.overflow);
                end
            end
        end
    end

    // predictor: take one accepted item into the set; on the closing item the
    // whole set is owed back in ascending order (signed compare) if owe_results
    function automatic void absorb_value(input t_in_item it, input bit owe_results);
        int pos;
        int n;
        t_out_item res;
        if (set_ascending.size() < DEPTH) begin
            pos = 0;
            while (pos < set_ascending.size() && set_ascending[pos] <= it.value)
                pos++;
            set_ascending.insert(pos, it.value);
        end else begin
            set_dropped = 1'b1;
        end
        if (it.last) begin
            n = set_ascending.size();
            if (owe_results) begin
                for (int k = 0; k < n; k++) begin
                    res.sorted_value = set_ascending[k];
                    res.final_res    = (k == n - 1);
                    res.overflow     = set_dropped;
                    sorted_expect.push_back(res);
                end
            end
            set_ascending.delete();
            set_dropped = 1'b0;
        end
    endfunction

    // offer one item, with a random gap first; returns after acceptance,
    // at the next falling edge
    task automatic offer_item(input t_in_item it, input bit typed, input t_out_item want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_data  <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        absorb_value(it, !typed);
        if (typed)
            sorted_expect.push_back(want);
        @(negedge i_clk);
    endtask

    function automatic t_key pick_value();
        case ($urandom_range(0, 9))
            0:       return KEY_MAX;
            1:       return KEY_MIN;
            2, 3:    return t_key'($urandom_range(0, 8)) - 4;  // dense, lots of duplicates
            default: return t_key'($urandom());
        endcase
    endfunction

    task automatic send_set(input int size, inout int sent);
        t_in_item  it;
        t_out_item none;
        none = '0;
        for (int k = 0; k < size; k++) begin
            it.value = pick_value();
            it.last  = (k == size - 1);
            offer_item(it, 1'b0, none);
            sent++;
        end
    endtask

    function automatic t_stim_row row(input t_key v, input bit last);
        t_stim_row r;
        r.item.value = v;
        r.item.last  = last;
        r.typed      = 1'b0;
        r.want       = '0;
        return r;
    endfunction

    // single-value set: the value comes straight back as the final result
    function automatic t_stim_row single_row(input t_key v);
        t_stim_row r;
        r = row(v, 1'b1);
        r.typed             = 1'b1;
        r.want.sorted_value = v;
        r.want.final_res    = 1'b1;
        r.want.overflow     = 1'b0;
        return r;
    endfunction

    initial begin
        int sent;
        int budget;
        int pick;

        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data         = '0;
        i_ready        = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        set_dropped    = 1'b0;
        send_idle_pct  = 17;
        recv_idle_pct  = 72;

        // single-value sets at the extremes and around zero
        stim_rows.push_back(single_row(KEY_MAX));
        stim_rows.push_back(single_row(KEY_MIN));
        stim_rows.push_back(single_row(0));
        stim_rows.push_back(single_row(-1));
        // mixed signs, both extremes and a duplicate
        stim_rows.push_back(row(5, 1'b0));
        stim_rows.push_back(row(-3, 1'b0));
        stim_rows.push_back(row(KEY_MAX, 1'b0));
        stim_rows.push_back(row(KEY_MIN, 1'b0));
        stim_rows.push_back(row(5, 1'b0));
        stim_rows.push_back(row(0, 1'b0));
        stim_rows.push_back(row(-1, 1'b1));
        // pairs already in order and reversed
        stim_rows.push_back(row(1, 1'b0));
        stim_rows.push_back(row(2, 1'b1));
        stim_rows.push_back(row(2, 1'b0));
        stim_rows.push_back(row(1, 1'b1));
        // all equal
        stim_rows.push_back(row(7, 1'b0));
        stim_rows.push_back(row(7, 1'b0));
        stim_rows.push_back(row(7, 1'b1));
        // a negative value, then alternating bit patterns, one of them negative
        stim_rows.push_back(row(-100, 1'b0));
        stim_rows.push_back(row(32'sh5555_5555, 1'b0));
        stim_rows.push_back(row(32'shAAAA_AAAA, 1'b1));

        repeat (RESET_LEN) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_rows[r])
            offer_item(stim_rows[r].item, stim_rows[r].typed, stim_rows[r].want);

        // random sets under three idle patterns
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 17; recv_idle_pct = 72; end
                1: begin send_idle_pct = 72; recv_idle_pct = 17; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            sent   = 0;
            budget = (ph == 0) ? 72 : ((ph == 1) ? 36 : 20);
            // overflowing set first, it fills the store and drops the rest
            if (ph == 0)
                send_set(DEPTH + $urandom_range(1, 6), sent);
            while (sent < budget) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_set($urandom_range(1, 8), sent);
                else
                    send_set($urandom_range(9, 24), sent);
            end
        end
        i_valid <= 1'b0;

        // drain, then give the block time to show any stray result
        while (sorted_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0 && sorted_expect.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/hse_pkg.sv
design/hse_mem.sv
design/hse_cmp.sv
design/heap_sort_engine_unit.sv
bench/testbench.sv
